/* design/tile_map_screen_projection_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for tile_map_screen_projection
// Clocked assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_SCREEN_PROJECTION_ASSERT_SVH
`define TILE_MAP_SCREEN_PROJECTION_ASSERT_SVH

// checked only out of reset
`define TMSP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// checked at every edge, reset included
`define TMSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

/* design/tmsp_pkg.sv */
// ----------------------------------------------------------------------------
// tmsp_pkg
// Shared codes for the tile map / screen projection block.
// ----------------------------------------------------------------------------
package tmsp_pkg;

  // map types
  localparam logic [1:0] MAP_ORTHO = 2'd0;
  localparam logic [1:0] MAP_ISO   = 2'd1;

  // request direction
  localparam logic CMD_TO_SCREEN = 1'b0;
  localparam logic CMD_TO_MAP    = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_TILE_W   = 2'd0;
  localparam logic [1:0] CFG_TILE_H   = 2'd1;
  localparam logic [1:0] CFG_MAP_TYPE = 2'd2;

  localparam int unsigned RESET_TILE_SIZE = 32;
  localparam logic [1:0]  RESET_MAP_TYPE  = MAP_ORTHO;

endpackage

/* design/tmsp_queue.sv */
// ----------------------------------------------------------------------------
// tmsp_queue
// Two-entry queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module tmsp_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

/* design/tmsp_front.sv */
// ----------------------------------------------------------------------------
// tmsp_front
// Accepts requests, forms products, picks numerator and divisor per lane.
// ----------------------------------------------------------------------------
module tmsp_front #(
  parameter int CB    = 16,
  parameter int TB    = 11,
  parameter int NUM_W = CB + TB + 1,
  parameter int DEN_W = 2 * TB,
  parameter int ENT_W = 2 + 2 * NUM_W + 2 * DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [CB-1:0]    x_in_i,
  input  logic [CB-1:0]    y_in_i,
  input  logic [TB-1:0]    tile_width_i,
  input  logic [TB-1:0]    tile_height_i,
  input  logic [1:0]       map_type_i,
  input  logic             full_i,
  output logic             push_o,
  output logic [ENT_W-1:0] entry_o
);

  logic signed [NUM_W-1:0] xs, ys, tws, ths, a2, a3;
  logic                    a_ready;
  logic                    a_valid_q;
  logic signed [NUM_W-1:0] x_q, y_q, p0_q, p1_q, p2_q, p3_q;
  logic [DEN_W-1:0]        tw_q, th_q, area_q;
  logic                    cmd_q;
  logic [1:0]              type_q;
  logic signed [NUM_W-1:0] nx, ny;
  logic [DEN_W-1:0]        dx, dy;
  logic                    neg_x, neg_y;
  logic [NUM_W-1:0]        mag_x, mag_y;

  assign xs  = {{(NUM_W-CB){x_in_i[CB-1]}}, x_in_i};
  assign ys  = {{(NUM_W-CB){y_in_i[CB-1]}}, y_in_i};
  assign tws = {{(NUM_W-TB){1'b0}}, tile_width_i};
  assign ths = {{(NUM_W-TB){1'b0}}, tile_height_i};
  // isometric map to screen scales the diagonal sums
  assign a2  = (map_type_i == tmsp_pkg::MAP_ISO) ? xs - ys : xs;
  assign a3  = (map_type_i == tmsp_pkg::MAP_ISO) ? xs + ys : ys;

  assign a_ready    = !a_valid_q || !full_i;
  assign in_ready_o = a_ready;
  assign push_o     = a_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      x_q    <= xs;
      y_q    <= ys;
      p0_q   <= xs * ths;
      p1_q   <= ys * tws;
      p2_q   <= a2 * tws;
      p3_q   <= a3 * ths;
      tw_q   <= DEN_W'(tile_width_i);
      th_q   <= DEN_W'(tile_height_i);
      area_q <= DEN_W'(tile_width_i) * DEN_W'(tile_height_i);
      cmd_q  <= cmd_i;
      type_q <= map_type_i;
    end
  end

  // every rule becomes n / d; a zero divisor gives 0 / 1
  always_comb begin
    nx = '0;
    ny = '0;
    dx = DEN_W'(1);
    dy = DEN_W'(1);
    unique case (type_q)
      tmsp_pkg::MAP_ORTHO: begin
        if (cmd_q == tmsp_pkg::CMD_TO_MAP) begin
          if (tw_q != '0) begin
            nx = x_q;
            dx = tw_q;
          end
          if (th_q != '0) begin
            ny = y_q;
            dy = th_q;
          end
        end else begin
          nx = p2_q;
          ny = p3_q;
        end
      end
      tmsp_pkg::MAP_ISO: begin
        if (cmd_q == tmsp_pkg::CMD_TO_MAP) begin
          if (area_q != '0) begin
            nx = p0_q + p1_q;
            ny = p1_q - p0_q;
            dx = area_q;
            dy = area_q;
          end
        end else begin
          nx = p2_q;
          ny = p3_q;
          dx = DEN_W'(2);
          dy = DEN_W'(2);
        end
      end
      default: begin
        if (cmd_q == tmsp_pkg::CMD_TO_MAP) begin
          nx = x_q;
          ny = y_q;
        end
      end
    endcase
  end

  assign neg_x   = nx[NUM_W-1];
  assign neg_y   = ny[NUM_W-1];
  assign mag_x   = neg_x ? NUM_W'(-nx) : NUM_W'(nx);
  assign mag_y   = neg_y ? NUM_W'(-ny) : NUM_W'(ny);
  assign entry_o = {neg_x, neg_y, mag_x, mag_y, dx, dy};

endmodule

/* design/tmsp_back.sv */
// ----------------------------------------------------------------------------
// tmsp_back
// Pipelined restoring divider, two lanes, one quotient bit per stage,
// then sign, saturation and the output register.
// ----------------------------------------------------------------------------
module tmsp_back #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 22,
  parameter int OUT_W = 26,
  parameter int ENT_W = 2 + 2 * NUM_W + 2 * DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [ENT_W-1:0] q_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] x_out_o,
  output logic [OUT_W-1:0] y_out_o
);

  localparam int STG = NUM_W + 1;
  localparam logic [NUM_W-1:0] HI = NUM_W'((64'd1 << (OUT_W - 1)) - 64'd1);

  logic                   en;
  logic                   v_q   [STG];
  logic [1:0]             neg_q [STG];
  logic [NUM_W-1:0]       nq_q  [STG][2];
  logic [DEN_W-1:0]       rem_q [STG][2];
  logic [DEN_W-1:0]       den_q [STG][2];
  logic [NUM_W-1:0]       nq_nx [NUM_W][2];
  logic [DEN_W-1:0]       rem_nx[NUM_W][2];
  logic                   out_valid_q;
  logic [OUT_W-1:0]       x_out_q, y_out_q;
  logic [1:0]             in_neg;
  logic [NUM_W-1:0]       in_mag_x, in_mag_y;
  logic [DEN_W-1:0]       in_den_x, in_den_y;

  function automatic logic [OUT_W-1:0] sat(input logic neg, input logic [NUM_W-1:0] mag);
    logic [NUM_W-1:0] nm;
    nm = -mag;
    if (!neg) return (mag > HI) ? HI[OUT_W-1:0] : mag[OUT_W-1:0];
    else      return (mag > HI + NUM_W'(1)) ? ~HI[OUT_W-1:0] : nm[OUT_W-1:0];
  endfunction

  assign {in_neg, in_mag_x, in_mag_y, in_den_x, in_den_y} = q_entry_i;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STG; i++) v_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= q_valid_i;
      for (int i = 1; i < STG; i++) v_q[i] <= v_q[i-1];
      out_valid_q <= v_q[STG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q[0]    <= in_neg;
      nq_q[0][0]  <= in_mag_x;
      nq_q[0][1]  <= in_mag_y;
      rem_q[0][0] <= '0;
      rem_q[0][1] <= '0;
      den_q[0][0] <= in_den_x;
      den_q[0][1] <= in_den_y;
      x_out_q     <= sat(neg_q[STG-1][1], nq_q[STG-1][0]);
      y_out_q     <= sat(neg_q[STG-1][0], nq_q[STG-1][1]);
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DEN_W:0] rs, sub;
      logic           ge;
      assign rs  = {rem_q[k][l], nq_q[k][l][NUM_W-1]};
      assign ge  = (rs >= {1'b0, den_q[k][l]});
      assign sub = rs - {1'b0, den_q[k][l]};
      assign rem_nx[k][l] = ge ? sub[DEN_W-1:0] : rs[DEN_W-1:0];
      assign nq_nx[k][l]  = {nq_q[k][l][NUM_W-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        neg_q[k+1] <= neg_q[k];
        for (int l = 0; l < 2; l++) begin
          nq_q[k+1][l]  <= nq_nx[k][l];
          rem_q[k+1][l] <= rem_nx[k][l];
          den_q[k+1][l] <= den_q[k][l];
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;

endmodule

/* design/tile_map_screen_projection.sv */
// ----------------------------------------------------------------------------
// tile_map_screen_projection
// Converts coordinate pairs between tile-map and screen space.
// ----------------------------------------------------------------------------
// Throughput is one coordinate pair per clock while the output is not
// stalled. Every request passes through a multiply stage, a two-entry queue
// and a two-lane restoring divider that resolves one quotient bit per stage
// (COORD_BITS+TILE_BITS+1 stages), then saturation and the output register.
// Results saturate to the output width; a zero divisor gives zero.
// Configuration is to be written while idle; the block does not enforce it.
// Writes to index 3 are ignored.
module tile_map_screen_projection #(
  parameter int COORD_BITS = 16,
  parameter int TILE_BITS  = 11
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [TILE_BITS-1:0]            cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [COORD_BITS-1:0]           x_in_i,
  input  logic [COORD_BITS-1:0]           y_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_BITS+TILE_BITS-2:0] x_out_o,
  output logic [COORD_BITS+TILE_BITS-2:0] y_out_o
);

  localparam int NUM_W = COORD_BITS + TILE_BITS + 1;  // signed numerator
  localparam int DEN_W = 2 * TILE_BITS;               // tile area
  localparam int OUT_W = COORD_BITS + TILE_BITS - 1;
  localparam int ENT_W = 2 + 2 * NUM_W + 2 * DEN_W;

  logic [TILE_BITS-1:0] tile_width_q, tile_height_q;
  logic [1:0]           map_type_q;
  logic                 push, full, pop, q_valid;
  logic [ENT_W-1:0]     entry, q_entry;

  // config writes always land
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q  <= TILE_BITS'(tmsp_pkg::RESET_TILE_SIZE);
      tile_height_q <= TILE_BITS'(tmsp_pkg::RESET_TILE_SIZE);
      map_type_q    <= tmsp_pkg::RESET_MAP_TYPE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tmsp_pkg::CFG_TILE_W:   tile_width_q  <= cfg_data_i;
        tmsp_pkg::CFG_TILE_H:   tile_height_q <= cfg_data_i;
        tmsp_pkg::CFG_MAP_TYPE: map_type_q    <= cfg_data_i[1:0];
        default: ;  // unused index
      endcase
    end
  end

  // front: products and divisor selection
  tmsp_front #(
    .CB(COORD_BITS), .TB(TILE_BITS), .NUM_W(NUM_W), .DEN_W(DEN_W), .ENT_W(ENT_W)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .x_in_i, .y_in_i,
    .tile_width_i (tile_width_q),
    .tile_height_i(tile_height_q),
    .map_type_i   (map_type_q),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (entry)
  );

  // decouples front stalls from back stalls
  tmsp_queue #(.W(ENT_W)) u_queue (
    .clk_i, .rst_ni,
    .push_i (push),
    .data_i (entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (q_entry)
  );

  // back: divider pipeline, saturation, output register
  tmsp_back #(
    .NUM_W(NUM_W), .DEN_W(DEN_W), .OUT_W(OUT_W), .ENT_W(ENT_W)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .pop_o      (pop),
    .out_valid_o, .out_ready_i, .x_out_o, .y_out_o
  );

endmodule

/* design/tmsp_checker.sv */
// ----------------------------------------------------------------------------
// tmsp_checker
// Port-level checks for tile_map_screen_projection.
// ----------------------------------------------------------------------------
`include "tile_map_screen_projection_assert.svh"

module tmsp_checker #(
  parameter int COORD_BITS = 16,
  parameter int TILE_BITS  = 11
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [COORD_BITS+TILE_BITS-2:0] x_out_o,
  input logic [COORD_BITS+TILE_BITS-2:0] y_out_o
);

  property p_out_hold;
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_out_o) && $stable(y_out_o);
  endproperty

  property p_out_known;
    out_valid_o |-> !$isunknown({x_out_o, y_out_o});
  endproperty

  // nothing comes out while held in reset
  `TMSP_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  // a stalled result holds
  `TMSP_ASSERT(a_out_hold, clk_i, rst_ni, p_out_hold)

  // a presented result carries known data
  `TMSP_ASSERT(a_out_known, clk_i, rst_ni, p_out_known)

  // configuration never back-pressures
  `TMSP_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_o)

endmodule

bind tile_map_screen_projection tmsp_checker #(
  .COORD_BITS(COORD_BITS), .TILE_BITS(TILE_BITS)
) u_tmsp_checker (.*);

/* tb/sv/tile_map_screen_projection_checker.sv */
// ----------------------------------------------------------------------------
// Projection checker
// Watches the config, request and result channels, predicts each result
// from its own copy of the registers and compares in order.
// ----------------------------------------------------------------------------
module tile_map_screen_projection_checker #(
  parameter int COORD_BITS = 16,
  parameter int TILE_BITS  = 11
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [TILE_BITS-1:0]            cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            cmd_i,
  input  logic [COORD_BITS-1:0]           x_in_i,
  input  logic [COORD_BITS-1:0]           y_in_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [COORD_BITS+TILE_BITS-2:0] x_out_i,
  input  logic [COORD_BITS+TILE_BITS-2:0] y_out_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OB = COORD_BITS + TILE_BITS - 1;

  typedef struct packed {
    logic [OB-1:0] px;
    logic [OB-1:0] py;
  } coord_pair_t;

  logic [TILE_BITS-1:0] tile_w, tile_h;
  logic [1:0]           map_kind;
  coord_pair_t          expected_pairs[$];

  function automatic longint sat_div(longint n, longint d);
    return (d == 0) ? 0 : n / d;
  endfunction

  function automatic logic [OB-1:0] clamp(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (OB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OB-1:0];
  endfunction

  function automatic coord_pair_t project(logic to_map, logic [COORD_BITS-1:0] xi,
                                          logic [COORD_BITS-1:0] yi);
    longint x, y, tw, th, rx, ry;
    coord_pair_t r;
    x = longint'(signed'(xi));
    y = longint'(signed'(yi));
    tw = longint'(tile_w);
    th = longint'(tile_h);
    rx = 0;
    ry = 0;
    if (map_kind == tmsp_pkg::MAP_ORTHO) begin
      if (to_map == tmsp_pkg::CMD_TO_MAP) begin
        rx = sat_div(x, tw);
        ry = sat_div(y, th);
      end else begin
        rx = x * tw;
        ry = y * th;
      end
    end else if (map_kind == tmsp_pkg::MAP_ISO) begin
      if (to_map == tmsp_pkg::CMD_TO_MAP) begin
        rx = sat_div(x * th + y * tw, tw * th);
        ry = sat_div(y * tw - x * th, tw * th);
      end else begin
        rx = ((x - y) * tw) / 2;
        ry = ((x + y) * th) / 2;
      end
    end else if (to_map == tmsp_pkg::CMD_TO_MAP) begin
      rx = x;
      ry = y;
    end
    r.px = clamp(rx);
    r.py = clamp(ry);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coord_pair_t e;
    if (!rst_ni) begin
      tile_w = TILE_BITS'(tmsp_pkg::RESET_TILE_SIZE);
      tile_h = TILE_BITS'(tmsp_pkg::RESET_TILE_SIZE);
      map_kind = tmsp_pkg::RESET_MAP_TYPE;
      fail_count_o = 0;
      results_seen_o = 0;
      expected_pairs.delete();
      pending_o = 0;
    end else begin
      // results first: a request never leaves in the edge it enters
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (expected_pairs.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result x=%0d y=%0d", signed'(x_out_i), signed'(y_out_i));
        end else begin
          e = expected_pairs.pop_front();
          if (e.px !== x_out_i || e.py !== y_out_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       signed'(e.px), signed'(e.py), signed'(x_out_i), signed'(y_out_i));
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_pairs.insert(expected_pairs.size(), project(cmd_i, x_in_i, y_in_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          tmsp_pkg::CFG_TILE_W:   tile_w = cfg_data_i;
          tmsp_pkg::CFG_TILE_H:   tile_h = cfg_data_i;
          tmsp_pkg::CFG_MAP_TYPE: map_kind = cfg_data_i[1:0];
          default: ;
        endcase
      end
      pending_o = expected_pairs.size();
    end
  end
endmodule

/* tb/sv/tile_map_screen_projection_tb.sv */
// ----------------------------------------------------------------------------
// Projection testbench
// Drives configuration phases and coordinate requests under varied idling
// and back-pressure; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tile_map_screen_projection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 16;
  localparam int TB = 11;
  localparam int OB = CB + TB - 1;
  localparam int LATENCY = CB + TB + 5;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;  // index beyond the register list

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b1;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = '0;
  logic [TB-1:0] cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic          cmd_i = 1'b0;
  logic [CB-1:0] x_in_i = '0;
  logic [CB-1:0] y_in_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [OB-1:0] x_out_o, y_out_o;

  int     fail_count, pending, results_seen;
  int     send_idle_pct = 0;   // sender idle chance, percent
  int     recv_stall_pct = 0;  // receiver stall chance, percent
  int     hold_off_cycles = 0; // long receiver stall, counted below
  int     requests_sent = 0;
  int     cfg_writes = 0;
  longint cycles = 0;

  always #10 clk_i = ~clk_i;

  tile_map_screen_projection #(.COORD_BITS(CB), .TILE_BITS(TB)) dut (.*);

  tile_map_screen_projection_checker #(.COORD_BITS(CB), .TILE_BITS(TB)) chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .x_in_i, .y_in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .x_out_i(x_out_o), .y_out_i(y_out_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen));

  // receiver: random stalls, plus a counted long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [TB-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_writes++;
  endtask

  // one request; random idle cycles in front of it, valid left high after
  task automatic send_request(logic c, logic [CB-1:0] x, logic [CB-1:0] y);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i  <= c;
    x_in_i <= x;
    y_in_i <= y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // wait for every expected result, then let the pipe drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic configure(logic [TB-1:0] tw, logic [TB-1:0] th, logic [1:0] mt);
    drain();
    write_reg(tmsp_pkg::CFG_TILE_W, tw);
    write_reg(tmsp_pkg::CFG_TILE_H, th);
    write_reg(tmsp_pkg::CFG_MAP_TYPE, {{(TB-2){1'b0}}, mt});
    cfg_valid_i <= 1'b0;
  endtask

  // coordinate value biased toward extremes and small values
  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return CB'($urandom_range(64)) - 16'd32;
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic [TB-1:0] rand_tile();
    case ($urandom_range(5))
      0: return 11'd1;
      1: return 11'd1024;
      2: return 11'h7ff;
      3: return 11'd0; // zero divisor case
      default: return TB'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic random_burst(int n);
    repeat (n) send_request(1'($urandom), rand_coord(), rand_coord());
  endtask

  initial begin
    logic [CB-1:0] edge_vals[4];
    edge_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, then iso and passthrough types, extremes
    for (int mt = 0; mt < 4; mt++) begin
      configure(mt == 0 ? 11'd32 : 11'd1024, mt == 0 ? 11'd32 : 11'd7, 2'(mt));
      for (int k = 0; k < 3; k++)
        send_request(1'(k & 1), edge_vals[k], edge_vals[3 - k]);
    end
    configure(11'd0, 11'd5, tmsp_pkg::MAP_ISO);      // zero width
    send_request(tmsp_pkg::CMD_TO_MAP, 16'd100, 16'd200);
    send_request(tmsp_pkg::CMD_TO_SCREEN, 16'h7fff, 16'h8000);
    configure(11'h7ff, 11'd0, tmsp_pkg::MAP_ORTHO);  // maximum width, zero height
    send_request(tmsp_pkg::CMD_TO_MAP, 16'h8000, 16'h7fff);
    send_request(tmsp_pkg::CMD_TO_SCREEN, 16'h8000, 16'h8000);
    drain();
    write_reg(CFG_UNUSED, 11'h7ff);                  // ignored
    cfg_valid_i <= 1'b0;

    // random phases over idling modes and settings
    for (int ph = 0; ph < 16; ph++) begin
      configure(rand_tile(), rand_tile(), 2'($urandom_range(3)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 5) begin
        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        hold_off_cycles <= 300;
      end
      random_burst(52);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain();
    $display("covered %0d requests, %0d results, %0d register writes, all map types",
             requests_sent, results_seen, cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending);
      $display("status: fail");
    end
    $finish;
  end
endmodule
